>>> rtl/trme_pkg.sv
// Shared constants, payload types and lookup tables for the register machine executor.
`default_nettype none

package trme_pkg;

  localparam int MemWords     = 64;
  localparam int ProgramLines = 256;
  localparam int NumRegs      = 5;
  localparam int DataW        = 32;
  localparam int AddrFieldW   = 6;
  localparam int AddrSpan     = 1 << AddrFieldW;
  localparam int LineFieldW   = 9;
  localparam int RegIdxW      = $clog2(NumRegs);

  localparam int MemDepth = (MemWords < AddrSpan) ? MemWords : AddrSpan;
  localparam int MemAddrW = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int LineW    = ($clog2(ProgramLines + 1) > LineFieldW) ?
                            $clog2(ProgramLines + 1) : LineFieldW;

  localparam logic [2:0] ActMov = 3'd0;
  localparam logic [2:0] ActAdd = 3'd1;
  localparam logic [2:0] ActSub = 3'd2;
  localparam logic [2:0] ActJmp = 3'd3;
  localparam logic [2:0] ActJpn = 3'd4;
  localparam logic [2:0] ActPrn = 3'd5;
  localparam logic [2:0] ActHlt = 3'd6;

  localparam logic [1:0] SrcReg = 2'd0;
  localparam logic [1:0] SrcMem = 2'd1;

  localparam logic [1:0] ErrNone       = 2'd0;
  localparam logic [1:0] ErrPastEnd    = 2'd1;
  localparam logic [1:0] ErrMemToMem   = 2'd2;
  localparam logic [1:0] ErrTargetZero = 2'd3;

  typedef logic [MemAddrW-1:0] mem_addr_t;
  typedef logic [RegIdxW-1:0]  reg_idx_t;

  typedef struct packed {
    logic [2:0]            action;
    logic                  first_is_memory;
    logic [2:0]            first_reg;
    logic [AddrFieldW-1:0] first_addr;
    logic [1:0]            src_kind;
    logic [2:0]            src_reg;
    logic [AddrFieldW-1:0] src_addr;
    logic [30:0]           immediate;
    logic [LineFieldW-1:0] target_line;
    logic                  jump_on_register;
  } in_word_t;

  typedef struct packed {
    logic [LineFieldW-1:0] next_line;
    logic                  print_valid;
    logic signed [31:0]    print_value;
    logic                  halted;
    logic [1:0]            error_code;
  } out_word_t;

  typedef struct packed {
    logic             en;
    reg_idx_t         addr;
    logic [DataW-1:0] data;
  } reg_wr_t;

  typedef struct packed {
    logic             en;
    mem_addr_t        addr;
    logic [DataW-1:0] data;
  } mem_wr_t;

  typedef mem_addr_t mem_lut_t [AddrSpan];

  function automatic mem_lut_t build_mem_lut();
    mem_lut_t lut;
    for (int i = 0; i < AddrSpan; i++) begin
      lut[i] = mem_addr_t'(i % MemDepth);
    end
    return lut;
  endfunction

  localparam mem_lut_t MemIndexLut = build_mem_lut();

endpackage

`default_nettype wire

>>> rtl/trme_regfile.sv
// Register file memory with two registered read ports, one write port and write bypass.
`default_nettype none

module trme_regfile (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        re,
  input  wire trme_pkg::reg_idx_t          raddr_a,
  input  wire trme_pkg::reg_idx_t          raddr_b,
  input  wire trme_pkg::reg_wr_t           wr,
  output      logic [trme_pkg::DataW-1:0]  rdata_a,
  output      logic [trme_pkg::DataW-1:0]  rdata_b
);

  logic [trme_pkg::DataW-1:0] ram_r [trme_pkg::NumRegs];
  logic [trme_pkg::NumRegs-1:0] vld_r;
  logic [trme_pkg::DataW-1:0] q_a_r;
  logic [trme_pkg::DataW-1:0] q_b_r;
  logic [trme_pkg::DataW-1:0] byp_data_r;
  logic byp_a_r;
  logic byp_b_r;
  logic live_a_r;
  logic live_b_r;
  logic in_range_a;
  logic in_range_b;

  assign in_range_a = (32'(raddr_a) < trme_pkg::NumRegs);
  assign in_range_b = (32'(raddr_b) < trme_pkg::NumRegs);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ram_r[wr.addr] <= wr.data;
    end
    if (re && in_range_a) begin
      q_a_r <= ram_r[raddr_a];
    end
    if (re && in_range_b) begin
      q_b_r <= ram_r[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      byp_a_r    <= wr.en && (wr.addr == raddr_a);
      byp_b_r    <= wr.en && (wr.addr == raddr_b);
      byp_data_r <= wr.data;
      live_a_r   <= in_range_a ? vld_r[raddr_a] : 1'b0;
      live_b_r   <= in_range_b ? vld_r[raddr_b] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  assign rdata_a = byp_a_r ? byp_data_r : (live_a_r ? q_a_r : '0);
  assign rdata_b = byp_b_r ? byp_data_r : (live_b_r ? q_b_r : '0);

endmodule

`default_nettype wire

>>> rtl/trme_dmem.sv
// Data word memory with one registered read port, one write port and write bypass.
`default_nettype none

module trme_dmem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        re,
  input  wire trme_pkg::mem_addr_t         raddr,
  input  wire trme_pkg::mem_wr_t           wr,
  output      logic [trme_pkg::DataW-1:0]  rdata
);

  logic [trme_pkg::DataW-1:0] ram_r [trme_pkg::MemDepth];
  logic [trme_pkg::MemDepth-1:0] vld_r;
  logic [trme_pkg::DataW-1:0] q_r;
  logic [trme_pkg::DataW-1:0] byp_data_r;
  logic byp_r;
  logic live_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ram_r[wr.addr] <= wr.data;
    end
    if (re) begin
      q_r <= ram_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      byp_r      <= wr.en && (wr.addr == raddr);
      byp_data_r <= wr.data;
      live_r     <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  assign rdata = byp_r ? byp_data_r : (live_r ? q_r : '0);

endmodule

`default_nettype wire

>>> rtl/tiny_register_machine_executor.sv
// Top level of the register machine executor: read stage, execute stage and output register.
//
// The executor takes one decoded instruction word per clock cycle while in_stall is low and
// returns one result word per instruction; the result word becomes valid at the clock edge
// after the one that accepts the instruction, when the output side does not stall. A stalled
// result word stalls the input in the same cycle only when the execute stage holds a word.
// The register file and the data memory are synchronous memories read at the edge that
// accepts a word; the execute stage executes the instruction and, unless stalled, writes back
// at most one register or memory word, updates the line counter and halt flag, and loads the
// output register. A write made at the same edge as the next word's read is bypassed inside
// each memory, so back-to-back dependent instructions see current values. Registers and
// memory words read as zero until first written after reset, which needs no clearing pass.
`default_nettype none

module tiny_register_machine_executor (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire trme_pkg::in_word_t   in_word,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      trme_pkg::out_word_t  out_word
);

  logic accept;
  logic rd_first_mem;
  trme_pkg::mem_addr_t mem_raddr;

  logic s1_valid_r;
  logic s1_valid_nxt;
  trme_pkg::in_word_t s1_word_r;
  logic s1_go;

  logic out_valid_r;
  logic out_valid_nxt;
  trme_pkg::out_word_t out_word_r;

  logic [trme_pkg::LineW-1:0] lc_r;
  logic [trme_pkg::LineW-1:0] lc_nxt;
  logic stopped_r;
  logic stopped_nxt;

  logic [trme_pkg::DataW-1:0] reg_a;
  logic [trme_pkg::DataW-1:0] reg_b;
  logic [trme_pkg::DataW-1:0] mem_val;
  logic [trme_pkg::DataW-1:0] src_val;
  logic [trme_pkg::DataW-1:0] imm_val;
  logic [trme_pkg::DataW-1:0] pval;
  logic pvalid;
  logic [1:0] err;
  logic take;

  logic reg_want;
  logic [2:0] reg_widx;
  logic [trme_pkg::DataW-1:0] reg_wdata;
  logic mem_want;
  trme_pkg::mem_addr_t mem_waddr;
  logic [trme_pkg::DataW-1:0] mem_wdata;

  trme_pkg::reg_wr_t reg_wr;
  trme_pkg::mem_wr_t mem_wr;
  trme_pkg::out_word_t result;

  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = !rst_n || (s1_valid_r && !s1_go);
  assign accept   = in_valid && !in_stall;

  assign rd_first_mem = (in_word.action == trme_pkg::ActMov) && in_word.first_is_memory &&
                        (in_word.src_kind == trme_pkg::SrcReg);
  assign mem_raddr = trme_pkg::MemIndexLut[rd_first_mem ? in_word.first_addr
                                                        : in_word.src_addr];

  trme_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .re      (accept),
    .raddr_a (trme_pkg::reg_idx_t'(in_word.first_reg)),
    .raddr_b (trme_pkg::reg_idx_t'(in_word.src_reg)),
    .wr      (reg_wr),
    .rdata_a (reg_a),
    .rdata_b (reg_b)
  );

  trme_dmem u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (accept),
    .raddr (mem_raddr),
    .wr    (mem_wr),
    .rdata (mem_val)
  );

  assign imm_val = {1'b0, s1_word_r.immediate};

  always_comb begin
    case (s1_word_r.src_kind)
      trme_pkg::SrcReg: src_val = reg_b;
      trme_pkg::SrcMem: src_val = mem_val;
      default:          src_val = imm_val;
    endcase
  end

  always_comb begin
    reg_want    = 1'b0;
    reg_widx    = s1_word_r.first_reg;
    reg_wdata   = imm_val;
    mem_want    = 1'b0;
    mem_waddr   = trme_pkg::MemIndexLut[s1_word_r.first_addr];
    mem_wdata   = imm_val;
    err         = trme_pkg::ErrNone;
    pvalid      = 1'b0;
    pval        = '0;
    take        = 1'b0;
    stopped_nxt = stopped_r;
    lc_nxt      = lc_r;
    if (stopped_r) begin
      lc_nxt = lc_r;
    end else if (lc_r >= trme_pkg::LineW'(trme_pkg::ProgramLines)) begin
      err = trme_pkg::ErrPastEnd;
    end else begin
      lc_nxt = lc_r + trme_pkg::LineW'(1);
      unique case (s1_word_r.action) inside
        trme_pkg::ActMov: begin
          if (!s1_word_r.first_is_memory) begin
            if (s1_word_r.src_kind == trme_pkg::SrcReg) begin
              reg_want  = 1'b1;
              reg_widx  = s1_word_r.src_reg;
              reg_wdata = reg_a;
            end else if (s1_word_r.src_kind == trme_pkg::SrcMem) begin
              mem_want  = 1'b1;
              mem_waddr = trme_pkg::MemIndexLut[s1_word_r.src_addr];
              mem_wdata = reg_a;
            end else begin
              reg_want  = 1'b1;
              reg_wdata = imm_val;
            end
          end else begin
            if (s1_word_r.src_kind == trme_pkg::SrcReg) begin
              reg_want  = 1'b1;
              reg_widx  = s1_word_r.src_reg;
              reg_wdata = mem_val;
            end else if (s1_word_r.src_kind == trme_pkg::SrcMem) begin
              err = trme_pkg::ErrMemToMem;
            end else begin
              mem_want = 1'b1;
            end
          end
        end
        trme_pkg::ActAdd: begin
          reg_want  = 1'b1;
          reg_wdata = reg_a + src_val;
        end
        trme_pkg::ActSub: begin
          reg_want  = 1'b1;
          reg_wdata = reg_a - src_val;
        end
        trme_pkg::ActJmp, trme_pkg::ActJpn: begin
          if (s1_word_r.target_line == '0) begin
            err = trme_pkg::ErrTargetZero;
          end else begin
            if (s1_word_r.action == trme_pkg::ActJmp) begin
              take = !s1_word_r.jump_on_register || (reg_a == '0);
            end else begin
              take = (reg_a == '0) || reg_a[trme_pkg::DataW-1];
            end
            if (take) begin
              lc_nxt = trme_pkg::LineW'(s1_word_r.target_line) - trme_pkg::LineW'(1);
            end
          end
        end
        trme_pkg::ActPrn: begin
          pvalid = 1'b1;
          pval   = src_val;
        end
        trme_pkg::ActHlt: begin
          stopped_nxt = 1'b1;
        end
        default: begin
          lc_nxt = lc_r + trme_pkg::LineW'(1);
        end
      endcase
      if (!stopped_nxt && (err == trme_pkg::ErrNone) &&
          (lc_nxt >= trme_pkg::LineW'(trme_pkg::ProgramLines))) begin
        err = trme_pkg::ErrPastEnd;
      end
    end
  end

  always_comb begin
    reg_wr.en   = s1_go && reg_want && (32'(reg_widx) < trme_pkg::NumRegs);
    reg_wr.addr = trme_pkg::reg_idx_t'(reg_widx);
    reg_wr.data = reg_wdata;
    mem_wr.en   = s1_go && mem_want;
    mem_wr.addr = mem_waddr;
    mem_wr.data = mem_wdata;
  end

  always_comb begin
    result.next_line   = lc_nxt[trme_pkg::LineFieldW-1:0];
    result.print_valid = pvalid;
    result.print_value = $signed(pval);
    result.halted      = stopped_nxt;
    result.error_code  = err;
  end

  assign s1_valid_nxt  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_go ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lc_r        <= '0;
      stopped_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        lc_r      <= lc_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
    end
    if (s1_go) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

>>> rtl/trme_checker.sv
// Port-level checker for the register machine executor and its bind statement.
`default_nettype none

module trme_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire trme_pkg::out_word_t  out_word
);

  logic halt_seen_r;
  logic [trme_pkg::LineFieldW-1:0] halt_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_word.halted) begin
      halt_seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall && out_word.halted && !halt_seen_r) begin
      halt_line_r <= out_word.next_line;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("Stalled result word changed or was dropped.");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && halt_seen_r |->
      out_word.halted && (out_word.next_line == halt_line_r))
    else $error("Result after halt left the halted state or moved the line.");

  a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.halted |->
      (out_word.error_code == trme_pkg::ErrNone) && !out_word.print_valid)
    else $error("Halted result carries an error or a print.");

  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.print_valid |->
      (out_word.error_code == trme_pkg::ErrNone) ||
      (out_word.error_code == trme_pkg::ErrPastEnd))
    else $error("Printed value reported together with an operand error.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result word valid right after reset.");

endmodule

bind tiny_register_machine_executor trme_checker u_trme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
